/* design/mtg_pkg.sv */
package mtg_pkg;

    localparam int TABLE_WORDS  = 624;
    localparam int TWIST_SHIFT  = 397;
    localparam int TWIST_SPAN   = TABLE_WORDS - TWIST_SHIFT;
    localparam int ADDR_W       = $clog2(TABLE_WORDS);
    localparam int POS_W        = $clog2(TABLE_WORDS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [31:0] LOWER_BITS   = 32'h7FFF_FFFF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] LCG_MUL      = 32'h0001_0DCD;
    localparam logic [31:0] DEFAULT_SEED = 32'h0000_1105;

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    // command handed from the front to the back
    typedef struct packed {
        logic        seed_op;
        logic [31:0] seed;
    } cmd_t;

    function automatic logic [31:0] mix_word(input logic [31:0] hi_src,
                                             input logic [31:0] lo_src,
                                             input logic [31:0] far);
        logic [31:0] y;
        y = (hi_src & UPPER_BIT) | (lo_src & LOWER_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] k;
        k = w;
        k = k ^ (k >> 11);
        k = k ^ ((k << 7) & TEMPER_B);
        k = k ^ ((k << 15) & TEMPER_C);
        k = k ^ (k >> 18);
        return k;
    endfunction

endpackage

/* design/mersenne_twister_generator_top.sv */
// MT19937 generator: a beat with mode 0 reseeds the 624-word state table from
// the 32-bit seed (zero stands for 4357) and returns nothing; a beat with mode
// 1 returns one tempered 32-bit word. Beats first land in a two-entry queue,
// so until it is full the input side keeps taking beats while the engine
// works and while a finished word waits on the output register. The twist is
// done lazily: each request regenerates exactly the table word it reads, from
// a two-read-port table memory, so a next request goes through accept, memory
// read, and twist plus temper into the output register, the last step waiting
// while that register holds an untaken word. A seed request runs the seeding
// LCG, one 32-bit by 17-bit multiply per cycle, two steps per table word. A
// next request issued before any seed returns words from an unwritten table.
module mersenne_twister_generator_top import mtg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] seed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    // front to back command channel
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // front: beat acceptance, seed fixup, command queue
    mtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .seed_value (seed_value),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // back: seeding sequencer, lazy twist, tempering, output register
    mtg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

endmodule

/* design/mtg_front.sv */
module mtg_front import mtg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] seed_value,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    // classify the beat and resolve the zero seed here
    always_comb
    begin
        cmd_in.seed_op = (mode == MODE_SEED);
        cmd_in.seed    = (seed_value == 32'd0) ? DEFAULT_SEED : seed_value;
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

/* design/mtg_back.sv */
module mtg_back import mtg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_MIX
    } state_t;

    state_t            state_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] p_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic              phase_reg;
    logic [31:0]       x_reg;
    logic [31:0]       x_next;
    logic [15:0]       hi_reg;
    logic [31:0]       cur_reg;
    logic              out_valid_reg;
    logic [31:0]       out_word_reg;

    logic [31:0]       table_mem [TABLE_WORDS];
    logic [31:0]       rd_a_reg;
    logic [31:0]       rd_b_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [31:0]       seed_word;
    logic [31:0]       new_word;
    logic              out_free;
    logic              seed_last;

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign out_free    = !out_valid_reg || out_ready;

    // lcg step, one multiply per cycle
    assign x_next    = 32'(x_reg * LCG_MUL + 32'd1);
    assign seed_word = {hi_reg, x_reg[31:16]};
    assign seed_last = phase_reg && (cnt_reg == ADDR_W'(TABLE_WORDS - 1));

    // neighbor word and far word of the twist at p
    assign addr_a = (p_reg == ADDR_W'(TABLE_WORDS - 1)) ? '0 : p_reg + ADDR_W'(1);
    assign addr_b = (p_reg < ADDR_W'(TWIST_SPAN)) ? p_reg + ADDR_W'(TWIST_SHIFT)
                                                   : p_reg - ADDR_W'(TWIST_SPAN);
    assign rd_en  = (state_reg == ST_READ);

    assign new_word = mix_word(cur_reg, rd_a_reg, rd_b_reg);

    assign wr_en   = ((state_reg == ST_SEED) && phase_reg) ||
                     ((state_reg == ST_MIX) && out_free);
    assign wr_addr = (state_reg == ST_SEED) ? cnt_reg : p_reg;
    assign wr_data = (state_reg == ST_SEED) ? seed_word : new_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= table_mem[addr_a];
            rd_b_reg <= table_mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_W'(TABLE_WORDS);
            p_reg         <= '0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            x_reg         <= '0;
            hi_reg        <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            // a new word in the mix state takes over the output register itself
            if (out_valid_reg && out_ready && (state_reg != ST_MIX))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.seed_op)
                        begin
                            x_reg     <= cmd.seed;
                            cnt_reg   <= '0;
                            phase_reg <= 1'b0;
                            state_reg <= ST_SEED;
                        end
                        else
                        begin
                            p_reg     <= (pos_reg >= POS_W'(TABLE_WORDS)) ? '0
                                         : pos_reg[ADDR_W-1:0];
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_SEED:
                begin
                    x_reg     <= x_next;
                    phase_reg <= !phase_reg;
                    if (!phase_reg)
                    begin
                        hi_reg <= x_reg[31:16];
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            cur_reg <= seed_word;
                        end
                        cnt_reg <= cnt_reg + ADDR_W'(1);
                        if (seed_last)
                        begin
                            pos_reg   <= POS_W'(TABLE_WORDS);
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    if (out_free)
                    begin
                        out_word_reg  <= temper(new_word);
                        out_valid_reg <= 1'b1;
                        cur_reg       <= rd_a_reg;
                        pos_reg       <= POS_W'(p_reg) + POS_W'(1);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(TABLE_WORDS))
        else $error("read position out of range");

    a_mix_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("twisted word not presented");

    a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED && seed_last) |=> (pos_reg == POS_W'(TABLE_WORDS)))
        else $error("seed did not rearm regeneration");

endmodule
